[rtl/espt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espt_pkg: shared constants of the encoder speed pll tracker
// widths of the result fields and gains, register map and reset values
// ----------------------------------------------------------------------------
package espt_pkg;

   // result field widths
   localparam int STEP_WIDTH  = 14;
   localparam int SUM_WIDTH   = 48;
   localparam int WORD_WIDTH  = 32;

   // gain format, unsigned q24 with one integer bit
   localparam int GAIN_WIDTH  = 25;
   localparam int GAIN_FRAC   = 24;

   // register port
   localparam int ADDR_WIDTH  = 4;
   localparam int DATA_WIDTH  = 32;
   localparam int INDEX_WIDTH = 2;

   typedef logic [INDEX_WIDTH-1:0] reg_index_type;

   localparam reg_index_type REG_REVERSE = 2'd0;
   localparam reg_index_type REG_KP_GAIN = 2'd1;
   localparam reg_index_type REG_KI_GAIN = 2'd2;

   localparam logic [GAIN_WIDTH-1:0] KP_GAIN_RESET = 25'd3355443;
   localparam logic [GAIN_WIDTH-1:0] KI_GAIN_RESET = 25'd67109;

endpackage
`default_nettype wire

[rtl/encoder_speed_pll_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_pll_tracker: encoder step, unwrapped position and pi pll
// one absolute encoder sample in, one result out: wrapped step, unwrapped
// position and the phase and speed of an angle tracking pi loop
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall / req_position, one encoder
//   sample per request, only the low POSITION_BITS bits are used
//   result channel: rsp_valid / rsp_stall and four payload ports, one result
//   for every request, in request order
//   register port: apb style, reverse_direction at 0x0, kp_gain at 0x4,
//   ki_gain at 0x8; write only while no request is in flight
//   an accepted request passes the request and then the result register
//   before rsp_valid; throughput: one request per cycle while rsp_stall is low;
//   the loop state (previous sample, position sum, phase, speed) is updated in
//   the same cycle that a result is produced, so the phase error subtract, the
//   two 26x32 gain multiplies and phase and speed adders form the critical path
//   rsp stall: the result register holds; the request register still
//   takes one more request, and req_stall rises only while both are full
//   reset: synchronous, clears valids, gains back to their reset values,
//   previous sample to half a revolution, sum, phase and speed to zero
// ----------------------------------------------------------------------------
module encoder_speed_pll_tracker #(
   parameter int POSITION_BITS = 14
) (
   input  wire                                     clock,
   input  wire                                     reset,
   // request channel
   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire  [POSITION_BITS-1:0]                req_position,
   // result channel
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic signed [espt_pkg::STEP_WIDTH-1:0]  rsp_angle_step,
   output logic signed [espt_pkg::SUM_WIDTH-1:0]   rsp_unwrapped_position,
   output logic [espt_pkg::WORD_WIDTH-1:0]         rsp_pll_phase_out,
   output logic signed [espt_pkg::WORD_WIDTH-1:0]  rsp_pll_speed_out,
   // register port
   input  wire                                     psel,
   input  wire                                     penable,
   input  wire                                     pwrite,
   input  wire  [espt_pkg::ADDR_WIDTH-1:0]         paddr,
   input  wire  [espt_pkg::DATA_WIDTH-1:0]         pwdata,
   output logic [espt_pkg::DATA_WIDTH-1:0]         prdata,
   output logic                                    pready
);

   localparam int SW = espt_pkg::SUM_WIDTH;
   localparam int WW = espt_pkg::WORD_WIDTH;
   localparam int GW = espt_pkg::GAIN_WIDTH;
   localparam int GF = espt_pkg::GAIN_FRAC;
   // product of a 26 bit signed gain and a 32 bit signed error
   localparam int PW = GW + 1 + WW;
   // scaled product after the q24 shift
   localparam int QW = PW - GF;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic                                   reverse_ff;
   logic [GW-1:0]                          kp_gain_ff;
   logic [GW-1:0]                          ki_gain_ff;

   logic                                   in_valid_ff;
   logic [POSITION_BITS-1:0]               in_position_ff;

   logic                                   out_valid_ff;
   logic                                   out_valid_in;
   logic [espt_pkg::STEP_WIDTH-1:0]        angle_step_ff;
   logic [espt_pkg::STEP_WIDTH-1:0]        angle_step_in;

   // loop state; all but the previous sample are also the result payload
   logic [POSITION_BITS-1:0]               prev_position_ff;
   logic [SW-1:0]                          position_sum_ff;
   logic [SW-1:0]                          position_sum_in;
   logic [WW-1:0]                          phase_ff;
   logic [WW-1:0]                          phase_in;
   logic [WW-1:0]                          speed_ff;
   logic [WW-1:0]                          speed_in;

   // ---------------------------------------------------------------------
   // handshake: the request register moves into the result stage whenever
   // the result register is empty or being drained
   // ---------------------------------------------------------------------
   logic advance;
   logic req_accept;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------
   espt_pkg::reg_index_type reg_index;
   logic                    reg_write;

   assign reg_index = paddr[espt_pkg::ADDR_WIDTH-1:2];
   assign reg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      case (reg_index)
         espt_pkg::REG_REVERSE: prdata = {{(espt_pkg::DATA_WIDTH-1){1'b0}}, reverse_ff};
         espt_pkg::REG_KP_GAIN: prdata = {{(espt_pkg::DATA_WIDTH-GW){1'b0}}, kp_gain_ff};
         espt_pkg::REG_KI_GAIN: prdata = {{(espt_pkg::DATA_WIDTH-GW){1'b0}}, ki_gain_ff};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
         kp_gain_ff <= espt_pkg::KP_GAIN_RESET;
         ki_gain_ff <= espt_pkg::KI_GAIN_RESET;
      end else if (reg_write) begin
         case (reg_index)
            espt_pkg::REG_REVERSE: reverse_ff <= pwdata[0];
            espt_pkg::REG_KP_GAIN: kp_gain_ff <= pwdata[GW-1:0];
            espt_pkg::REG_KI_GAIN: ki_gain_ff <= pwdata[GW-1:0];
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // wrapped step and unwrapped position
   // ---------------------------------------------------------------------
   logic [POSITION_BITS-1:0] diff;
   logic [SW-1:0]            step_ext;
   logic [SW-1:0]            sum_add;

   // modular difference, its top bit is the sign of the wrapped step
   assign diff     = in_position_ff - prev_position_ff;
   assign step_ext = {{(SW-POSITION_BITS){diff[POSITION_BITS-1]}}, diff};
   assign sum_add  = reverse_ff ? (~step_ext + 1'b1) : step_ext;

   assign position_sum_in = position_sum_ff + sum_add;
   assign angle_step_in   = step_ext[espt_pkg::STEP_WIDTH-1:0];

   // ---------------------------------------------------------------------
   // pi phase locked loop
   // ---------------------------------------------------------------------
   logic [WW-1:0]        meas_phase;
   logic [WW-1:0]        phase_err;
   logic signed [PW-1:0] kp_prod;
   logic signed [PW-1:0] ki_prod;
   logic [QW-1:0]        ki_scaled;
   logic [QW:0]          speed_sum;

   // sample scaled to a 32 bit revolution
   assign meas_phase = {in_position_ff, {(WW-POSITION_BITS){1'b0}}};
   // modular subtract, read as signed
   assign phase_err  = meas_phase - phase_ff;

   assign kp_prod = $signed({{(WW+1){1'b0}}, kp_gain_ff})
                  * $signed({{(GW+1){phase_err[WW-1]}}, phase_err});
   assign ki_prod = $signed({{(WW+1){1'b0}}, ki_gain_ff})
                  * $signed({{(GW+1){phase_err[WW-1]}}, phase_err});

   // phase wraps mod 2^32, so only the low word of the floor-scaled term counts
   assign phase_in = phase_ff + speed_ff + kp_prod[GF+WW-1:GF];

   // speed adds the floor-scaled integral term and saturates
   assign ki_scaled = ki_prod[PW-1:GF];
   assign speed_sum = {{(QW-WW+1){speed_ff[WW-1]}}, speed_ff}
                    + {ki_scaled[QW-1], ki_scaled};

   always_comb begin
      speed_in = speed_sum[WW-1:0];
      if (speed_sum[QW] && !(&speed_sum[QW-1:WW-1])) begin
         // below -2^31
         speed_in = {1'b1, {(WW-1){1'b0}}};
      end else if (!speed_sum[QW] && (|speed_sum[QW-1:WW-1])) begin
         // above 2^31-1
         speed_in = {1'b0, {(WW-1){1'b1}}};
      end
   end

   // ---------------------------------------------------------------------
   // control and state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         prev_position_ff <= {1'b1, {(POSITION_BITS-1){1'b0}}};
         position_sum_ff  <= '0;
         phase_ff         <= '0;
         speed_ff         <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            prev_position_ff <= in_position_ff;
            position_sum_ff  <= position_sum_in;
            phase_ff         <= phase_in;
            speed_ff         <= speed_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_position_ff <= req_position;
      end
      if (advance) begin
         angle_step_ff <= angle_step_in;
      end
   end

   // ---------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------
   assign rsp_valid              = out_valid_ff;
   assign rsp_angle_step         = $signed(angle_step_ff);
   assign rsp_unwrapped_position = $signed(position_sum_ff);
   assign rsp_pll_phase_out      = phase_ff;
   assign rsp_pll_speed_out      = $signed(speed_ff);

endmodule
`default_nettype wire

[rtl/espt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// espt_checker: port level checks of the encoder speed pll tracker
// handshake ordering and result hold under stall
// ----------------------------------------------------------------------------
module espt_checker (
   input wire                                    clock,
   input wire                                    reset,
   input wire                                    req_valid,
   input wire                                    req_stall,
   input wire                                    rsp_valid,
   input wire                                    rsp_stall,
   input wire [espt_pkg::STEP_WIDTH-1:0]         rsp_angle_step,
   input wire [espt_pkg::SUM_WIDTH-1:0]          rsp_unwrapped_position,
   input wire [espt_pkg::WORD_WIDTH-1:0]         rsp_pll_phase_out,
   input wire [espt_pkg::WORD_WIDTH-1:0]         rsp_pll_speed_out
);

   // reset empties the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side only stalls when the output side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result");

   // a new result follows a request accepted through the request and result registers
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a request");

   // stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_angle_step)
         && $stable(rsp_unwrapped_position) && $stable(rsp_pll_phase_out)
         && $stable(rsp_pll_speed_out)))
      else $error("stalled result changed");

endmodule

bind encoder_speed_pll_tracker espt_checker u_espt_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_angle_step         (rsp_angle_step),
   .rsp_unwrapped_position (rsp_unwrapped_position),
   .rsp_pll_phase_out      (rsp_pll_phase_out),
   .rsp_pll_speed_out      (rsp_pll_speed_out)
);
`default_nettype wire
